// ===== hdl/nlcrc_pkg.sv =====
package nlcrc_pkg;

	localparam int unsigned BYTE_W   = 8;
	localparam int unsigned CRC_W    = 16;
	localparam int unsigned STATUS_W = 2;
	localparam int unsigned PHASE_W  = 2;

	localparam logic [CRC_W-1:0]  CRC_POLY = 16'h1021;
	localparam logic [CRC_W-1:0]  CRC_INIT = 16'h0000;
	localparam logic [BYTE_W-1:0] BYTE_LF  = 8'h0A;
	localparam logic [BYTE_W-1:0] BYTE_EOF = 8'h1A;

	localparam logic [PHASE_W-1:0] PH_HEADER = 2'd0;
	localparam logic [PHASE_W-1:0] PH_BODY   = 2'd1;
	localparam logic [PHASE_W-1:0] PH_DONE   = 2'd2;

	localparam logic [STATUS_W-1:0] ST_MATCH    = 2'd0;
	localparam logic [STATUS_W-1:0] ST_MISMATCH = 2'd1;
	localparam logic [STATUS_W-1:0] ST_EMPTY    = 2'd2;

	typedef struct packed {
		logic [CRC_W-1:0]    computed_crc;
		logic [STATUS_W-1:0] status;
	} result_t;

	// msb-first byte fold, no reflection
	function automatic logic [CRC_W-1:0] crc_fold(
		input logic [CRC_W-1:0]  crc,
		input logic [BYTE_W-1:0] data
	);
		logic [CRC_W-1:0] c;
		c = crc ^ {data, {(CRC_W-BYTE_W){1'b0}}};
		for (int k = 0; k < BYTE_W; k++) begin
			if (c[CRC_W-1]) begin
				c = {c[CRC_W-2:0], 1'b0} ^ CRC_POLY;
			end else begin
				c = {c[CRC_W-2:0], 1'b0};
			end
		end
		return c;
	endfunction

endpackage

// ===== hdl/nodelist_crc16_verify_unit.sv =====
// channel   | beat fields (lsb first)                | end mark
// s_axis    | tdata: data_byte[7:0]; tuser: has_byte | tlast = last
// m_axis    | tdata: status[1:0], computed_crc[17:2] | none
// cfg       | cfg_wr_data: target_crc[15:0]          | none
//
// one byte per cycle save a stalled end-of-file; input register to result register
// the byte-wide crc fold sits between the input register and the stream state
// a result waits in the output register while the next beats are taken
// arst_n clears stream state, the target crc register and both valid flags
// a stalled result holds only the end-of-file beat behind it
module nodelist_crc16_verify_unit
	import nlcrc_pkg::*;
#(
	parameter int unsigned LINE_LIMIT = 1023
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_wr_en,
	input  logic [15:0] cfg_wr_data,    // target_crc[15:0]
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [7:0]  s_axis_tdata,   // data_byte[7:0]
	input  logic        s_axis_tuser,   // has_byte
	input  logic        s_axis_tlast,
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [23:0] m_axis_tdata    // status[1:0], computed_crc[17:2], zero pad
);

	localparam int unsigned CNT_W = $clog2(LINE_LIMIT + 1);
	localparam logic [CNT_W:0] LIMIT_EXT = (CNT_W+1)'(LINE_LIMIT);

	logic [CRC_W-1:0]   target_crc_q;

	logic               s1_valid_q;
	logic [BYTE_W-1:0]  data_s1;
	logic               has_s1;
	logic               last_s1;

	logic [CRC_W-1:0]   crc_q;
	logic [PHASE_W-1:0] phase_q;
	logic [CNT_W-1:0]   hdr_cnt_q;
	logic               seen_q;

	logic [CRC_W-1:0]   crc_nxt;
	logic [PHASE_W-1:0] phase_nxt;
	logic [CNT_W-1:0]   hdr_cnt_nxt;
	logic               seen_nxt;
	logic [CNT_W:0]     hdr_inc;

	logic               out_valid_q;
	result_t            out_q;
	result_t            res;

	logic               out_free;
	logic               s1_adv;
	logic               in_acc;

	assign out_free      = !out_valid_q || m_axis_tready;
	assign s1_adv        = s1_valid_q && (!last_s1 || out_free);
	assign s_axis_tready = !s1_valid_q || s1_adv;
	assign in_acc        = s_axis_tvalid && s_axis_tready;

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {{(24-CRC_W-STATUS_W){1'b0}}, out_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			target_crc_q <= '0;
		end else if (cfg_wr_en) begin
			target_crc_q <= cfg_wr_data;
		end
	end

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q <= 1'b0;
		end else if (in_acc) begin
			s1_valid_q <= 1'b1;
		end else if (s1_adv) begin
			s1_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			data_s1 <= s_axis_tdata;
			has_s1  <= s_axis_tuser;
			last_s1 <= s_axis_tlast;
		end
	end

	always_comb begin
		crc_nxt     = crc_q;
		phase_nxt   = phase_q;
		hdr_cnt_nxt = hdr_cnt_q;
		seen_nxt    = seen_q;
		hdr_inc     = {1'b0, hdr_cnt_q} + 1'b1;
		if (has_s1) begin
			seen_nxt = 1'b1;
			case (phase_q)
				PH_HEADER: begin
					hdr_cnt_nxt = hdr_inc[CNT_W-1:0];
					if (data_s1 == BYTE_LF || hdr_inc >= LIMIT_EXT) begin
						phase_nxt = PH_BODY;
					end
				end
				PH_BODY: begin
					if (data_s1 == BYTE_EOF) begin
						phase_nxt = PH_DONE;
					end else begin
						crc_nxt = crc_fold(crc_q, data_s1);
					end
				end
				default: begin
				end
			endcase
		end
		if (!seen_nxt) begin
			res.status       = ST_EMPTY;
			res.computed_crc = '0;
		end else begin
			res.status       = (crc_nxt == target_crc_q) ? ST_MATCH : ST_MISMATCH;
			res.computed_crc = crc_nxt;
		end
	end

	// stream state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			crc_q     <= CRC_INIT;
			phase_q   <= PH_HEADER;
			hdr_cnt_q <= '0;
			seen_q    <= 1'b0;
		end else if (s1_adv) begin
			if (last_s1) begin
				crc_q     <= CRC_INIT;
				phase_q   <= PH_HEADER;
				hdr_cnt_q <= '0;
				seen_q    <= 1'b0;
			end else begin
				crc_q     <= crc_nxt;
				phase_q   <= phase_nxt;
				hdr_cnt_q <= hdr_cnt_nxt;
				seen_q    <= seen_nxt;
			end
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (s1_adv && last_s1) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_adv && last_s1) begin
			out_q <= res;
		end
	end

	a_clear_after_eof: assert property (@(posedge clk) disable iff (!arst_n)
		s1_adv && last_s1 |=> phase_q == PH_HEADER && !seen_q && crc_q == CRC_INIT)
		else $error("stream state not cleared after end of file");

	a_empty_zero_crc: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && out_q.status == ST_EMPTY |-> out_q.computed_crc == '0)
		else $error("empty file result carries nonzero crc");

	a_hdr_below_limit: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == PH_HEADER |-> {1'b0, hdr_cnt_q} < LIMIT_EXT)
		else $error("header count reached limit while still in header");

	a_eof_waits: assert property (@(posedge clk) disable iff (!arst_n)
		s1_valid_q && last_s1 && out_valid_q && !m_axis_tready |=> s1_valid_q && last_s1)
		else $error("end-of-file beat dropped while result stalled");

	a_no_beat_untracked: assert property (@(posedge clk) disable iff (!arst_n)
		s1_valid_q && !s1_adv |-> !s_axis_tready)
		else $error("input taken while stage one holds");

endmodule
